// ----- hdl/sbd_pkg.sv -----
// Package for the sRGB box downsampler: shared constants, control types and
// the two constant ROMs (sRGB to linear, linear to sRGB thresholds).
// Depends on nothing; every other file in hdl uses it by scoped names.
package sbd_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_OUT_WIDTH_DEF = 1024;
   localparam int MAX_FACTOR_DEF    = 8;

   // Linear values are Q0.LIN_W fractions.
   localparam int    LIN_W   = 16;
   localparam longint LIN_ONE = longint'(1) << LIN_W;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_FACTOR     = 2'd0,
      CSR_OUT_WIDTH  = 2'd1,
      CSR_OUT_HEIGHT = 2'd2
   } csr_index_type;

   // Control flags that travel with each queued word.
   typedef struct packed {
      logic pass;       // factor of one: copy the pixel straight out
      logic first;      // first sample of a box: overwrite the accumulator
      logic emit;       // last sample of a box: produce a pixel
      logic frame_end;  // the produced pixel closes the frame
   } ctl_type;

   localparam int CTL_W = $bits(ctl_type);

   // ROM contents: 256 entries, one bit of headroom for the threshold ROM.
   typedef logic [LIN_W:0] rom_type [256];

   localparam int BIG_W = 512;

   function automatic logic [BIG_W-1:0] big_pow(input longint base, input int e);
      logic [BIG_W-1:0] r;
      r = BIG_W'(1);
      for (int k = 0; k < e; k++) begin
         r = r * BIG_W'(base);
      end
      return r;
   endfunction

   // Compares a^5 * b^12 with c^12 * 2^s, giving -1, 0 or 1.
   function automatic int pow_cmp(input longint a, input longint b, input longint c,
                                  input int s);
      logic [BIG_W-1:0] x;
      logic [BIG_W-1:0] y;
      x = big_pow(a, 5) * big_pow(b, 12);
      y = big_pow(c, 12) << s;
      if (x > y) return 1;
      if (x < y) return -1;
      return 0;
   endfunction

   // sRGB code to linear: linear segment near black, power law above it.
   function automatic longint lin_entry(input int v);
      longint q;
      longint lo;
      longint hi;
      longint mid;
      if (v <= 10) begin
         q = (longint'(20) * v * LIN_ONE + 32946) / 65892;
      end else begin
         lo = 1;
         hi = LIN_ONE;
         while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (pow_cmp(2 * mid - 1, 269025, longint'(1000) * v + 14025,
                        5 * (LIN_W + 1)) <= 0) begin
               lo = mid;
            end else begin
               hi = mid - 1;
            end
         end
         q = lo;
      end
      if (q > LIN_ONE - 1) q = LIN_ONE - 1;
      return q;
   endfunction

   // Smallest linear mean that encodes to code c.
   function automatic longint thr_entry(input int c);
      longint m;
      longint lo;
      longint hi;
      longint mid;
      if (c == 0) begin
         m = 0;
      end else if (c <= 10) begin
         m = (longint'(5) * (2 * c - 1) * LIN_ONE + 32945) / 32946;
      end else begin
         lo = 0;
         hi = LIN_ONE;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (pow_cmp(mid, 53805, longint'(200) * c + 2705, 5 * LIN_W) >= 0) begin
               hi = mid;
            end else begin
               lo = mid + 1;
            end
         end
         m = lo;
      end
      return m;
   endfunction

   function automatic rom_type build_lin_rom();
      rom_type r;
      for (int v = 0; v < 256; v++) begin
         r[v] = (LIN_W + 1)'(lin_entry(v));
      end
      return r;
   endfunction

   function automatic rom_type build_thr_rom();
      rom_type r;
      for (int c = 0; c < 256; c++) begin
         r[c] = (LIN_W + 1)'(thr_entry(c));
      end
      return r;
   endfunction

   localparam rom_type LIN_ROM = build_lin_rom();
   localparam rom_type THR_ROM = build_thr_rom();

endpackage

// ----- hdl/sbd_front.sv -----
// Front end of the sRGB box downsampler: configuration registers, raster
// counters and classification of each source pixel into a queued word.
// Depends on sbd_pkg.
module sbd_front #(
   parameter int MAX_OUT_WIDTH = sbd_pkg::MAX_OUT_WIDTH_DEF,
   parameter int MAX_FACTOR    = sbd_pkg::MAX_FACTOR_DEF,
   parameter int F_W           = $clog2(MAX_FACTOR + 1),
   parameter int COL_W         = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1,
   parameter int QW            = sbd_pkg::CTL_W + F_W + COL_W + 24
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write_enable,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_write_data,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [7:0]    req_src_red,
   input  logic [7:0]    req_src_green,
   input  logic [7:0]    req_src_blue,
   input  logic          q_full,
   output logic          q_push,
   output logic [QW-1:0] q_push_data
);

   localparam int WID_W = $clog2(MAX_OUT_WIDTH + 1);

   logic [3:0]       factor_ff;
   logic [10:0]      out_width_ff;
   logic [15:0]      out_height_ff;
   logic [F_W-1:0]   sample_col_ff, sample_col_in;
   logic [F_W-1:0]   sample_row_ff, sample_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [15:0]      out_row_ff, out_row_in;

   logic [F_W-1:0]   f_eff;
   logic [WID_W-1:0] w_eff;
   logic [15:0]      h_eff;
   logic [F_W:0]     sc_next, sr_next;
   logic [COL_W:0]   oc_next;
   logic [16:0]      or_next;
   sbd_pkg::ctl_type ctl;
   logic             accept;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff     <= 4'd1;
         out_width_ff  <= 11'd1;
         out_height_ff <= 16'd1;
      end else if (csr_write_enable) begin
         unique case (sbd_pkg::csr_index_type'(csr_index))
            sbd_pkg::CSR_FACTOR:     factor_ff     <= csr_write_data[3:0];
            sbd_pkg::CSR_OUT_WIDTH:  out_width_ff  <= csr_write_data[10:0];
            sbd_pkg::CSR_OUT_HEIGHT: out_height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Effective limits, with zero taken as one and oversize values saturated.
   always_comb begin
      if (factor_ff == 4'd0) begin
         f_eff = F_W'(1);
      end else if (32'(factor_ff) > MAX_FACTOR) begin
         f_eff = F_W'(MAX_FACTOR);
      end else begin
         f_eff = F_W'(factor_ff);
      end
      if (out_width_ff == 11'd0) begin
         w_eff = WID_W'(1);
      end else if (32'(out_width_ff) > MAX_OUT_WIDTH) begin
         w_eff = WID_W'(MAX_OUT_WIDTH);
      end else begin
         w_eff = WID_W'(out_width_ff);
      end
      h_eff = (out_height_ff == 16'd0) ? 16'd1 : out_height_ff;
   end

   assign accept    = req_valid && req_ready;
   assign req_ready = !q_full;
   assign sc_next   = {1'b0, sample_col_ff} + (F_W + 1)'(1);
   assign sr_next   = {1'b0, sample_row_ff} + (F_W + 1)'(1);
   assign oc_next   = {1'b0, out_col_ff} + (COL_W + 1)'(1);
   assign or_next   = {1'b0, out_row_ff} + 17'd1;

   // Classification of the current sample.
   always_comb begin
      ctl.pass      = (f_eff == F_W'(1));
      ctl.first     = (sample_col_ff == '0) && (sample_row_ff == '0);
      ctl.emit      = (sc_next >= {1'b0, f_eff}) && (sr_next >= {1'b0, f_eff});
      ctl.frame_end = (32'(oc_next) >= 32'(w_eff)) && (or_next >= {1'b0, h_eff});
   end

   assign q_push      = accept;
   assign q_push_data = {ctl, f_eff, out_col_ff, req_src_red, req_src_green, req_src_blue};

   // Raster counters: sample within box, box column, sample row, box row.
   always_comb begin
      sample_col_in = sample_col_ff;
      sample_row_in = sample_row_ff;
      out_col_in    = out_col_ff;
      out_row_in    = out_row_ff;
      if (accept) begin
         if (sc_next >= {1'b0, f_eff}) begin
            sample_col_in = '0;
            if (32'(oc_next) >= 32'(w_eff)) begin
               out_col_in = '0;
               if (sr_next >= {1'b0, f_eff}) begin
                  sample_row_in = '0;
                  out_row_in    = (or_next >= {1'b0, h_eff}) ? 16'd0 : or_next[15:0];
               end else begin
                  sample_row_in = sr_next[F_W-1:0];
               end
            end else begin
               out_col_in = oc_next[COL_W-1:0];
            end
         end else begin
            sample_col_in = sc_next[F_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_col_ff <= '0;
         sample_row_ff <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
      end else begin
         sample_col_ff <= sample_col_in;
         sample_row_ff <= sample_row_in;
         out_col_ff    <= out_col_in;
         out_row_ff    <= out_row_in;
      end
   end

endmodule

// ----- hdl/sbd_queue.sv -----
// Short first-in first-out queue that decouples the front end from the back
// end of the sRGB box downsampler. Depends on sbd_pkg for its depth.
module sbd_queue #(
   parameter int QW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  logic [QW-1:0] push_data,
   output logic          full,
   input  logic          pop,
   output logic [QW-1:0] pop_data,
   output logic          empty
);

   localparam int DEPTH = sbd_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);

   logic [QW-1:0]    entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]   count_ff;

   assign full     = (count_ff == (PTR_W + 1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   // Storage for queued words.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         if (push && !pop) begin
            count_ff <= count_ff + (PTR_W + 1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (PTR_W + 1)'(1);
         end
      end
   end

endmodule

// ----- hdl/sbd_back.sv -----
// Back end of the sRGB box downsampler: column accumulators, iterative
// division by the box area, threshold search and the result register.
// Depends on sbd_pkg for the ROMs and the control word type.
module sbd_back #(
   parameter int MAX_OUT_WIDTH = sbd_pkg::MAX_OUT_WIDTH_DEF,
   parameter int MAX_FACTOR    = sbd_pkg::MAX_FACTOR_DEF,
   parameter int F_W           = $clog2(MAX_FACTOR + 1),
   parameter int COL_W         = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1,
   parameter int QW            = sbd_pkg::CTL_W + F_W + COL_W + 24
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_empty,
   input  logic [QW-1:0] q_pop_data,
   output logic          q_pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [7:0]    rsp_out_red,
   output logic [7:0]    rsp_out_green,
   output logic [7:0]    rsp_out_blue,
   output logic          rsp_frame_end
);

   localparam int LIN_W  = sbd_pkg::LIN_W;
   localparam int SUM_W  = LIN_W + 2 * $clog2(MAX_FACTOR);
   localparam int AREA_W = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
   localparam int STEP_W = $clog2(SUM_W);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_ACC  = 5'b00010,
      S_DIV  = 5'b00100,
      S_ENC  = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   sbd_pkg::ctl_type cmd_ctl_ff;
   logic [F_W-1:0]   cmd_f_ff;
   logic [COL_W-1:0] cmd_idx_ff;
   logic [7:0]       cmd_rgb_ff [3];

   logic [3*SUM_W-1:0] acc_mem [MAX_OUT_WIDTH];
   logic [3*SUM_W-1:0] rd_ff;

   logic [SUM_W-1:0]  dvd_ff [3];
   logic [SUM_W-1:0]  dvd_in [3];
   logic [AREA_W-1:0] rem_ff [3];
   logic [AREA_W-1:0] rem_in [3];
   logic [AREA_W-1:0] area_ff, area_in;
   logic [7:0]        code_ff [3];
   logic [7:0]        code_in [3];

   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_rgb_ff [3];
   logic [7:0]       rsp_rgb_in [3];
   logic             rsp_fe_ff, rsp_fe_in;

   sbd_pkg::ctl_type head_ctl;
   logic [F_W-1:0]   head_f;
   logic [COL_W-1:0] head_idx;
   logic [7:0]       head_rgb [3];
   logic             out_free;
   logic             rsp_load;
   logic [SUM_W-1:0] acc_sum [3];
   logic [SUM_W-1:0] lin_val [3];
   logic [AREA_W:0]  trial [3];
   logic [AREA_W:0]  diff [3];
   logic [7:0]       cand [3];
   logic [2*F_W-1:0] area_full;

   // Unpack the word at the head of the queue.
   assign head_ctl    = sbd_pkg::ctl_type'(q_pop_data[QW-1 -: sbd_pkg::CTL_W]);
   assign head_f      = q_pop_data[COL_W+24 +: F_W];
   assign head_idx    = q_pop_data[24 +: COL_W];
   assign head_rgb[0] = q_pop_data[23:16];
   assign head_rgb[1] = q_pop_data[15:8];
   assign head_rgb[2] = q_pop_data[7:0];

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign q_pop    = (state_ff == S_IDLE) && !q_empty && (!head_ctl.pass || out_free);
   assign area_full = cmd_f_ff * cmd_f_ff;

   // Accumulator memory: registered read on pop, write back in S_ACC.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         rd_ff <= acc_mem[head_idx];
      end
      if (state_ff == S_ACC) begin
         acc_mem[cmd_idx_ff] <= {acc_sum[0], acc_sum[1], acc_sum[2]};
      end
   end

   // Command register.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ctl_ff <= head_ctl;
         cmd_f_ff   <= head_f;
         cmd_idx_ff <= head_idx;
         for (int i = 0; i < 3; i++) begin
            cmd_rgb_ff[i] <= head_rgb[i];
         end
      end
   end

   // Per-channel datapath: accumulate, divide one bit a step, search codes.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lin_val[i] = SUM_W'(sbd_pkg::LIN_ROM[cmd_rgb_ff[i]]);
         acc_sum[i] = cmd_ctl_ff.first ? lin_val[i]
                                       : rd_ff[(2-i)*SUM_W +: SUM_W] + lin_val[i];
         trial[i]   = {rem_ff[i], dvd_ff[i][SUM_W-1]};
         diff[i]    = trial[i] - {1'b0, area_ff};
         cand[i]    = code_ff[i] | (8'd1 << (3'd7 - step_ff[2:0]));
      end
   end

   // Sequencer for one back-end word.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      area_in  = area_ff;
      rsp_load = 1'b0;
      for (int i = 0; i < 3; i++) begin
         dvd_in[i]     = dvd_ff[i];
         rem_in[i]     = rem_ff[i];
         code_in[i]    = code_ff[i];
         rsp_rgb_in[i] = rsp_rgb_ff[i];
      end
      rsp_fe_in = rsp_fe_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (q_pop) begin
               if (head_ctl.pass) begin
                  rsp_load  = 1'b1;
                  rsp_fe_in = head_ctl.frame_end;
                  for (int i = 0; i < 3; i++) begin
                     rsp_rgb_in[i] = head_rgb[i];
                  end
               end else begin
                  state_in = S_ACC;
               end
            end
         end
         S_ACC: begin
            area_in = area_full[AREA_W-1:0];
            step_in = '0;
            for (int i = 0; i < 3; i++) begin
               dvd_in[i] = acc_sum[i];
               rem_in[i] = '0;
            end
            state_in = cmd_ctl_ff.emit ? S_DIV : S_IDLE;
         end
         S_DIV: begin
            for (int i = 0; i < 3; i++) begin
               if (trial[i] >= {1'b0, area_ff}) begin
                  rem_in[i] = diff[i][AREA_W-1:0];
                  dvd_in[i] = {dvd_ff[i][SUM_W-2:0], 1'b1};
               end else begin
                  rem_in[i] = trial[i][AREA_W-1:0];
                  dvd_in[i] = {dvd_ff[i][SUM_W-2:0], 1'b0};
               end
               code_in[i] = 8'd0;
            end
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               step_in  = '0;
               state_in = S_ENC;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         S_ENC: begin
            for (int i = 0; i < 3; i++) begin
               if (dvd_ff[i] >= SUM_W'(sbd_pkg::THR_ROM[cand[i]])) begin
                  code_in[i] = cand[i];
               end
            end
            if (step_ff[2:0] == 3'd7) begin
               state_in = S_OUT;
            end
            step_in = step_ff + STEP_W'(1);
         end
         S_OUT: begin
            if (out_free) begin
               rsp_load  = 1'b1;
               rsp_fe_in = cmd_ctl_ff.frame_end;
               for (int i = 0; i < 3; i++) begin
                  rsp_rgb_in[i] = code_ff[i];
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      area_ff   <= area_in;
      rsp_fe_ff <= rsp_fe_in;
      for (int i = 0; i < 3; i++) begin
         dvd_ff[i]     <= dvd_in[i];
         rem_ff[i]     <= rem_in[i];
         code_ff[i]    <= code_in[i];
         rsp_rgb_ff[i] <= rsp_rgb_in[i];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_rgb_ff[0];
   assign rsp_out_green = rsp_rgb_ff[1];
   assign rsp_out_blue  = rsp_rgb_ff[2];
   assign rsp_frame_end = rsp_fe_ff;

   // A copied pixel never enters the accumulate step.
   a_pass_skips_acc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACC) |-> !cmd_ctl_ff.pass)
      else $error("copied pixel reached the accumulate step");

   // A new result only appears from an idle copy or from the output step.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff) && !$past(reset))
      |-> ($past(state_ff) == S_IDLE || $past(state_ff) == S_OUT))
      else $error("result word raised from an unexpected state");

   // The code search runs straight into the output step.
   a_enc_flow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ENC) |=> (state_ff == S_ENC || state_ff == S_OUT))
      else $error("code search left for an unexpected state");

endmodule

// ----- hdl/srgb_box_downsampler_core.sv -----
// Top level of the sRGB box downsampler: front end, queue and back end.
// Depends on sbd_pkg, sbd_front, sbd_queue and sbd_back.
//
//   Channel  Direction  Handshake                       Word
//   req_     in         req_valid / req_ready           src_red, src_green, src_blue
//   rsp_     out        rsp_valid / rsp_ready           out_red/green/blue, frame_end
//   csr_     in         csr_write_enable                csr_index, csr_write_data
//
// A factor of one passes one pixel per cycle through the back end while the
// result register is free. Other samples go through an accumulator read, then
// an add and write back; the last sample of a box adds SUM_W division steps
// (22 at the defaults), eight threshold steps and an output step.
// Reset clears control state only; the accumulators need no clearing pass.
// The four-word queue lets the front keep accepting while the back works or
// the result register waits for rsp_ready.
module srgb_box_downsampler_core #(
   parameter int MAX_OUT_WIDTH = sbd_pkg::MAX_OUT_WIDTH_DEF,
   parameter int MAX_FACTOR    = sbd_pkg::MAX_FACTOR_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_src_red,
   input  logic [7:0]  req_src_green,
   input  logic [7:0]  req_src_blue,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_blue,
   output logic        rsp_frame_end
);

   localparam int F_W   = $clog2(MAX_FACTOR + 1);
   localparam int COL_W = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
   localparam int QW    = sbd_pkg::CTL_W + F_W + COL_W + 24;

   logic          q_push, q_pop, q_full, q_empty;
   logic [QW-1:0] q_push_data, q_pop_data;

   // Front end: configuration, counters, classification.
   sbd_front #(
      .MAX_OUT_WIDTH(MAX_OUT_WIDTH), .MAX_FACTOR(MAX_FACTOR),
      .F_W(F_W), .COL_W(COL_W), .QW(QW)
   ) u_front (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_src_red(req_src_red), .req_src_green(req_src_green),
      .req_src_blue(req_src_blue),
      .q_full(q_full), .q_push(q_push), .q_push_data(q_push_data)
   );

   // Queue between the two halves.
   sbd_queue #(.QW(QW)) u_queue (
      .clock(clock), .reset(reset),
      .push(q_push), .push_data(q_push_data), .full(q_full),
      .pop(q_pop), .pop_data(q_pop_data), .empty(q_empty)
   );

   // Back end: accumulation, division, encoding and the result register.
   sbd_back #(
      .MAX_OUT_WIDTH(MAX_OUT_WIDTH), .MAX_FACTOR(MAX_FACTOR),
      .F_W(F_W), .COL_W(COL_W), .QW(QW)
   ) u_back (
      .clock(clock), .reset(reset),
      .q_empty(q_empty), .q_pop_data(q_pop_data), .q_pop(q_pop),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_red(rsp_out_red), .rsp_out_green(rsp_out_green),
      .rsp_out_blue(rsp_out_blue), .rsp_frame_end(rsp_frame_end)
   );

endmodule
